FILE: rtl/core/sss_pkg.sv
// shared constants, register indexes and control types of the stepped stimulus sequencer
package sss_pkg;

    localparam int ADC_BITS   = 12;
    localparam int MAX_STEPS  = 8;
    localparam int STEP_W     = 3;
    localparam int CNT_W      = 16;
    localparam int SUM_W      = 28;
    localparam int TICK_W     = 24;
    localparam int SCALE_W    = 16;
    localparam int COUNT_W    = 4;
    localparam int CMD_W      = 16;
    localparam int DRIVE_W    = 17;
    localparam int FORCE_W    = 21;
    localparam int MAG_W      = ADC_BITS + 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam logic [FORCE_W-1:0] FORCE_LIMIT = 21'd1048320;

    localparam logic [CFG_IDX_W-1:0] REG_BACKWARD_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMMANDS_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COMMANDS_HIGH = 3'd6;

    localparam logic [CNT_W-1:0]   CALIB_SAMPLES_RST = 16'd500;
    localparam logic [TICK_W-1:0]  DWELL_TICKS_RST   = 24'd1500;
    localparam logic [SCALE_W-1:0] LEVER_SCALE_RST   = 16'd256;
    localparam logic [COUNT_W-1:0] COMMAND_COUNT_RST = 4'd8;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    typedef struct packed {
        logic load_item;
        logic store_latest;
        logic accumulate;
        logic cal_div_start;
        logic cal_commit;
        logic force_div_start;
        logic tick_advance;
        logic tick_finish;
        logic tick_inc;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_tick;
        logic calibrated;
        logic calib_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/sss_div.sv
// iterative restoring divider, one quotient bit per cycle
module sss_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sss_pkg::SUM_W-1:0]    dividend,
    input  logic [sss_pkg::SCALE_W-1:0]  divisor,
    output logic                         done,
    output logic [sss_pkg::SUM_W-1:0]    quotient
);

    localparam int N     = sss_pkg::SUM_W;
    localparam int D     = sss_pkg::SCALE_W;
    localparam int STEPS = N;
    localparam int CW    = $clog2(STEPS);

    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [D:0]    rem_shift;
    logic [D:0]    rem_sub;
    logic          ge;

    assign rem_shift = {rem_reg, quo_reg[N-1]};
    assign ge        = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[N-2:0], ge};
            rem_next = ge ? rem_sub[D-1:0] : rem_shift[D-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/sss_datapath.sv
// configuration registers, calibration and sequence state, force scaling and result register
module sss_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            in_action,
    input  logic [sss_pkg::ADC_BITS-1:0]    in_sample,
    input  sss_pkg::ctrl_cmd_t              cmd,
    output sss_pkg::dp_status_t             status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sss_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int A = sss_pkg::ADC_BITS;
    localparam int S = sss_pkg::STEP_W;

    logic                          backward_mode_reg;
    logic [sss_pkg::CNT_W-1:0]     calib_samples_reg;
    logic [sss_pkg::TICK_W-1:0]    dwell_ticks_reg;
    logic [sss_pkg::SCALE_W-1:0]   lever_scale_reg;
    logic [sss_pkg::COUNT_W-1:0]   command_count_reg;
    logic [sss_pkg::CFG_DATA_W-1:0] commands_low_reg;
    logic [sss_pkg::CFG_DATA_W-1:0] commands_high_reg;

    logic                          item_action_reg;
    logic [A-1:0]                  item_sample_reg;

    logic                          calibrated_reg;
    logic [sss_pkg::CNT_W-1:0]     calib_count_reg;
    logic [sss_pkg::SUM_W-1:0]     calib_sum_reg;
    logic [A-1:0]                  zero_offset_reg;
    logic [A-1:0]                  latest_sample_reg;
    logic [S-1:0]                  step_index_reg;
    logic [sss_pkg::TICK_W-1:0]    tick_count_reg;
    logic                          hold_elapsed_reg;
    logic                          sequence_done_reg;

    logic                          out_valid_reg;
    logic [sss_pkg::M_TDATA_W-1:0] out_data_reg;

    logic [sss_pkg::COUNT_W-1:0]   cc_m1;
    logic [S-1:0]                  last_idx;
    logic [S-1:0]                  step_inc;
    logic [S-1:0]                  read_idx;
    logic [2*sss_pkg::CFG_DATA_W-1:0] cmd_table;
    logic [sss_pkg::CMD_W-1:0]     entry;
    logic signed [sss_pkg::DRIVE_W-1:0] drive_cmd;
    logic [A:0]                    diff;
    logic [A-1:0]                  mag;
    logic [sss_pkg::FORCE_W-1:0]   force_mag;
    logic [sss_pkg::FORCE_W-1:0]   force_val;
    logic [sss_pkg::TICK_W-1:0]    tick_upd;
    logic [sss_pkg::SUM_W-1:0]     div_dividend;
    logic [sss_pkg::SCALE_W-1:0]   div_divisor;
    logic                          div_done;
    logic [sss_pkg::SUM_W-1:0]     div_quotient;

    sss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.cal_div_start | cmd.force_div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // entries in use, clamped to one .. MAX_STEPS
    always_comb begin
        cc_m1 = command_count_reg - sss_pkg::COUNT_W'(1);
        if (command_count_reg == '0) begin
            last_idx = '0;
        end else if (command_count_reg >= sss_pkg::COUNT_W'(sss_pkg::MAX_STEPS)) begin
            last_idx = S'(sss_pkg::MAX_STEPS - 1);
        end else begin
            last_idx = cc_m1[S-1:0];
        end
    end

    assign step_inc  = step_index_reg + S'(1);
    assign read_idx  = (step_index_reg > last_idx) ? last_idx : step_index_reg;
    assign cmd_table = {commands_high_reg, commands_low_reg};
    assign entry     = cmd_table[{read_idx, 4'b0000} +: sss_pkg::CMD_W];

    always_comb begin
        drive_cmd = sss_pkg::DRIVE_W'($signed(entry));
        if (backward_mode_reg) begin
            drive_cmd = -drive_cmd;
        end
    end

    assign diff = {1'b0, latest_sample_reg} - {1'b0, zero_offset_reg};
    assign mag  = diff[A] ? (~diff[A-1:0] + A'(1)) : diff[A-1:0];

    assign div_dividend = cmd.cal_div_start ? calib_sum_reg
                        : sss_pkg::SUM_W'({mag, 8'h00});
    assign div_divisor  = cmd.cal_div_start ? calib_count_reg : lever_scale_reg;

    always_comb begin
        if (lever_scale_reg == '0) begin
            force_mag = sss_pkg::FORCE_LIMIT;
        end else begin
            force_mag = {1'b0, div_quotient[sss_pkg::FORCE_W-2:0]};
        end
        if (diff == '0) begin
            force_val = '0;
        end else if (diff[A]) begin
            force_val = -force_mag;
        end else begin
            force_val = force_mag;
        end
    end

    assign tick_upd = cmd.tick_inc ? tick_count_reg + sss_pkg::TICK_W'(1) : tick_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backward_mode_reg <= 1'b0;
            calib_samples_reg <= sss_pkg::CALIB_SAMPLES_RST;
            dwell_ticks_reg   <= sss_pkg::DWELL_TICKS_RST;
            lever_scale_reg   <= sss_pkg::LEVER_SCALE_RST;
            command_count_reg <= sss_pkg::COMMAND_COUNT_RST;
            commands_low_reg  <= '0;
            commands_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sss_pkg::REG_BACKWARD_MODE: backward_mode_reg <= cfg_wr_data[0];
                sss_pkg::REG_CALIB_SAMPLES: calib_samples_reg <= cfg_wr_data[sss_pkg::CNT_W-1:0];
                sss_pkg::REG_DWELL_TICKS:   dwell_ticks_reg   <= cfg_wr_data[sss_pkg::TICK_W-1:0];
                sss_pkg::REG_LEVER_SCALE:   lever_scale_reg   <= cfg_wr_data[sss_pkg::SCALE_W-1:0];
                sss_pkg::REG_COMMAND_COUNT: command_count_reg <= cfg_wr_data[sss_pkg::COUNT_W-1:0];
                sss_pkg::REG_COMMANDS_LOW:  commands_low_reg  <= cfg_wr_data;
                sss_pkg::REG_COMMANDS_HIGH: commands_high_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_action_reg <= in_action;
            item_sample_reg <= in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibrated_reg    <= 1'b0;
            calib_count_reg   <= sss_pkg::CNT_W'(1);
            calib_sum_reg     <= '0;
            zero_offset_reg   <= '0;
            latest_sample_reg <= '0;
            step_index_reg    <= '0;
            tick_count_reg    <= '0;
            hold_elapsed_reg  <= 1'b0;
            sequence_done_reg <= 1'b0;
        end else begin
            if (cmd.store_latest) begin
                latest_sample_reg <= item_sample_reg;
            end
            if (cmd.accumulate) begin
                calib_sum_reg <= calib_sum_reg + sss_pkg::SUM_W'(item_sample_reg);
                // count stays put on the final sample, it becomes the divisor
                if (!status.calib_last) begin
                    calib_count_reg <= calib_count_reg + sss_pkg::CNT_W'(1);
                end
            end
            if (cmd.cal_commit) begin
                zero_offset_reg <= div_quotient[A-1:0];
                calibrated_reg  <= 1'b1;
            end
            if (cmd.tick_advance && !sequence_done_reg && hold_elapsed_reg) begin
                hold_elapsed_reg <= 1'b0;
                if (step_inc == '0 || step_inc > last_idx) begin
                    step_index_reg    <= last_idx;
                    sequence_done_reg <= 1'b1;
                end else begin
                    step_index_reg <= step_inc;
                end
            end
            if (cmd.tick_finish) begin
                if (tick_upd >= dwell_ticks_reg) begin
                    hold_elapsed_reg <= 1'b1;
                    tick_count_reg   <= '0;
                end else begin
                    tick_count_reg <= tick_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {sequence_done_reg, hold_elapsed_reg, force_val, drive_cmd};
        end
    end

    assign status.item_tick  = (item_action_reg == sss_pkg::ACTION_TICK);
    assign status.calibrated = calibrated_reg;
    assign status.calib_last = (calib_count_reg >= calib_samples_reg);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/sss_ctrl.sv
// controller state machine that sequences each transaction through the datapath
module sss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sss_pkg::dp_status_t  status,
    output sss_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_DISPATCH   = 3'd1;
    localparam logic [2:0] ST_CAL_START  = 3'd2;
    localparam logic [2:0] ST_CAL_WAIT   = 3'd3;
    localparam logic [2:0] ST_FORCE_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT        = 3'd5;
    localparam logic [2:0] ST_TICK_END   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!status.item_tick) begin
                    if (status.calibrated) begin
                        cmd.store_latest = 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        cmd.accumulate = 1'b1;
                        state_next     = status.calib_last ? ST_CAL_START : ST_IDLE;
                    end
                end else begin
                    cmd.tick_advance = 1'b1;
                    if (status.calibrated) begin
                        cmd.force_div_start = 1'b1;
                        state_next          = ST_FORCE_WAIT;
                    end else begin
                        state_next = ST_TICK_END;
                    end
                end
            end
            ST_CAL_START: begin
                cmd.cal_div_start = 1'b1;
                state_next        = ST_CAL_WAIT;
            end
            ST_CAL_WAIT: begin
                if (status.div_done) begin
                    cmd.cal_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FORCE_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.tick_finish = 1'b1;
                    cmd.tick_inc    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_TICK_END: begin
                cmd.tick_finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/stepped_stimulus_sequencer_core.sv
// top level of the stepped stimulus sequencer: controller, datapath and assertions
//
//  channel  | direction | contents
//  s_       | in        | tdata: sample ; tuser: action (0 sample, 1 tick)
//  m_       | out       | tdata: drive_command, force_res, dwell_done, all_done
//  cfg_     | in        | write enable, register index, write data
//
//  a sample passes through dispatch only; the calibrating sample then waits on the 28-step divider
//  a tick passes through dispatch and tick end before calibration, and after it waits on the shared divider
//  one transaction at a time; the next is taken as soon as the result sits in the output register
//  a stalled m_ side holds the block only when a new result finds the output register still full
//  reset is synchronous and active low and needs no clearing pass
module stepped_stimulus_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sss_pkg::S_TDATA_W-1:0]   s_tdata,   // sample
    input  logic [0:0]                      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sss_pkg::M_TDATA_W-1:0]   m_tdata,   // drive_command, force_res, dwell_done, all_done
    input  logic                            cfg_wr_en,
    input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    sss_pkg::ctrl_cmd_t  ctrl_cmd;
    sss_pkg::dp_status_t dp_status;

    sss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    sss_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_action   (s_tuser[0]),
        .in_sample   (s_tdata[sss_pkg::ADC_BITS-1:0]),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while still held");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while one is in work");

    a_result_needs_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.out_load |-> dp_status.calibrated)
        else $error("result formed before calibration");
`endif

endmodule
